FILE: design/bemt_pkg.sv
package bemt_pkg;

  localparam int STEP_W      = 16;
  localparam int DUR_W       = 24;
  localparam int ELAPSED_W   = 25;
  localparam int POS_W       = 32;
  localparam int IDX_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_INOUT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_EASE_MODE = 3'd0,
    REG_DURATION  = 3'd1,
    REG_START_X   = 3'd2,
    REG_START_Y   = 3'd3,
    REG_START_Z   = 3'd4,
    REG_END_X     = 3'd5,
    REG_END_Y     = 3'd6,
    REG_END_Z     = 3'd7
  } reg_idx_t;

  localparam mode_t             MODE_RESET     = MODE_OUT;
  localparam logic [DUR_W-1:0]  DURATION_RESET = 24'd1000;

  typedef enum logic [1:0] {
    KIND_FINISH = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_TWEEN  = 2'd2
  } cmd_kind_t;

  // one classified tick, handed from front to back
  typedef struct packed {
    cmd_kind_t        kind;
    logic             first_half;
    logic [DUR_W-1:0] t;
  } cmd_t;

  typedef struct packed {
    mode_t            mode;
    logic [DUR_W-1:0] duration;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
    logic [POS_W-1:0] start_z;
    logic [POS_W-1:0] end_x;
    logic [POS_W-1:0] end_y;
    logic [POS_W-1:0] end_z;
  } cfg_t;

endpackage

FILE: design/bounce_easing_motion_tween.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | in_valid / in_stall        | time_step, restart
// output   | out_valid / out_stall      | pos_x, pos_y, pos_z, finished
// config   | wr_en                      | wr_index, wr_data
//
// A tick is taken every cycle while the two-entry queue between front and back has room.
// A tween result runs through S_DIV (the one-bit-per-cycle divider for alpha), S_SEG,
// S_SQ, S_WGT, S_MUL, S_DONE; end-position and mode-none results go to S_DONE directly.
// Restart and stopped ticks produce no result and leave the back untouched.
// rst is synchronous; it restores the register defaults, clears elapsed time, sets running.
// out_stall holds the result register; the front keeps taking ticks until the queue fills.
module bounce_easing_motion_tween #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bemt_pkg::STEP_W-1:0]       time_step,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bemt_pkg::POS_W-1:0] pos_x,
  output logic signed [bemt_pkg::POS_W-1:0] pos_y,
  output logic signed [bemt_pkg::POS_W-1:0] pos_z,
  output logic                              finished,
  input  logic                              wr_en,
  input  logic [bemt_pkg::IDX_W-1:0]        wr_index,
  input  logic [bemt_pkg::POS_W-1:0]        wr_data
);
  import bemt_pkg::*;

  cfg_t cfg;
  logic full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RESET;
      cfg.duration <= DURATION_RESET;
      cfg.start_x  <= '0;
      cfg.start_y  <= '0;
      cfg.start_z  <= '0;
      cfg.end_x    <= '0;
      cfg.end_y    <= '0;
      cfg.end_z    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_EASE_MODE: cfg.mode     <= mode_t'(wr_data[1:0]);
        REG_DURATION:  cfg.duration <= wr_data[DUR_W-1:0];
        REG_START_X:   cfg.start_x  <= wr_data;
        REG_START_Y:   cfg.start_y  <= wr_data;
        REG_START_Z:   cfg.start_z  <= wr_data;
        REG_END_X:     cfg.end_x    <= wr_data;
        REG_END_Y:     cfg.end_y    <= wr_data;
        REG_END_Z:     cfg.end_z    <= wr_data;
        default: ;
      endcase
    end
  end

  bemt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .time_step (time_step),
    .restart   (restart),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bemt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  bemt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .finished  (finished)
  );

endmodule

FILE: design/bemt_front.sv
module bemt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bemt_pkg::STEP_W-1:0]  time_step,
  input  logic                         restart,
  input  bemt_pkg::cfg_t               cfg,
  input  logic                         full,
  output logic                         push,
  output bemt_pkg::cmd_t               push_cmd
);
  import bemt_pkg::*;

  logic [ELAPSED_W-1:0] elapsed;
  logic                 running;

  logic                 accept;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] e_next;
  logic [ELAPSED_W:0]   twice_e;
  logic                 over;
  logic                 first_half;
  logic [DUR_W-1:0]     e_lo;
  logic [DUR_W-1:0]     e2_lo;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign push     = accept && !restart && running;

  always_comb begin
    sum        = {1'b0, elapsed} + (ELAPSED_W+1)'(time_step);
    e_next     = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
    over       = e_next > ELAPSED_W'(cfg.duration);
    twice_e    = {e_next, 1'b0};
    first_half = twice_e < (ELAPSED_W+1)'(cfg.duration);
    // in the tween case e_next <= duration, so the low bits carry everything
    e_lo       = e_next[DUR_W-1:0];
    e2_lo      = twice_e[DUR_W-1:0];

    push_cmd.first_half = first_half;
    push_cmd.kind       = KIND_TWEEN;
    push_cmd.t          = '0;
    if (over) begin
      push_cmd.kind = KIND_FINISH;
    end else begin
      unique case (cfg.mode)
        MODE_IN:  push_cmd.t = cfg.duration - e_lo;
        MODE_OUT: push_cmd.t = e_lo;
        MODE_INOUT: begin
          push_cmd.t = first_half ? (cfg.duration - e2_lo) : (e2_lo - cfg.duration);
        end
        default:  push_cmd.kind = KIND_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      running <= 1'b1;
    end else if (accept) begin
      if (restart) begin
        elapsed <= '0;
        running <= 1'b1;
      end else if (running) begin
        elapsed <= e_next;
        if (over) running <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bemt_queue.sv
module bemt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bemt_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output bemt_pkg::cmd_t pop_cmd
);
  import bemt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/bemt_back.sv
module bemt_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bemt_pkg::cfg_t                    cfg,
  input  logic                              pop_valid,
  input  bemt_pkg::cmd_t                    pop_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bemt_pkg::POS_W-1:0] pos_x,
  output logic signed [bemt_pkg::POS_W-1:0] pos_y,
  output logic signed [bemt_pkg::POS_W-1:0] pos_z,
  output logic                              finished
);
  import bemt_pkg::*;

  localparam int AW     = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int MAG_W  = FRAC_BITS + 4;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int W_W    = FRAC_BITS + 2;
  localparam int PROD_W = POS_W + 1 + W_W + 1;

  localparam logic [AW-1:0]   ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW+3:0]   LIM4  = {5'd4,  {FRAC_BITS{1'b0}}};
  localparam logic [AW+3:0]   LIM8  = {5'd8,  {FRAC_BITS{1'b0}}};
  localparam logic [AW+3:0]   LIM10 = {5'd10, {FRAC_BITS{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_SEG  = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_WGT  = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                    state;
  logic [DUR_W-1:0]          rem;
  logic [CNT_W-1:0]          cnt;
  logic [AW-1:0]             alpha;
  logic                      first_half;
  logic [MAG_W-1:0]          mag;
  logic [5:0]                seg_c;
  logic [SQ_W-1:0]           sq;
  logic [W_W-1:0]            w;
  logic [1:0]                axis;
  logic signed [PROD_W-1:0]  prod;

  // divider step
  logic [DUR_W:0]            trial;
  logic                      ge;
  logic [DUR_W-1:0]          rem_next;
  // bounce segment
  logic [AW+3:0]             a11;
  logic [AW+4:0]             a22;
  logic [4:0]                m;
  logic [5:0]                c;
  logic signed [AW+5:0]      s;
  logic [AW+5:0]             s_abs;
  // weight
  logic [SQ_W:0]             fsum;
  logic [SQ_W:0]             f_full;
  logic [AW-1:0]             f;
  logic [W_W-1:0]            w_next;
  // position
  logic [POS_W-1:0]          st_mul;
  logic [POS_W-1:0]          en_mul;
  logic signed [POS_W:0]     delta;
  logic signed [W_W:0]       w_s;
  logic [1:0]                axis_prev;
  logic [POS_W-1:0]          st_add;
  logic signed [PROD_W-1:0]  shifted;
  logic [POS_W-1:0]          pos_sum;

  assign pop       = (state == S_IDLE) && pop_valid;
  assign out_valid = state == S_DONE;

  always_comb begin
    trial    = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
    ge       = trial >= {1'b0, cfg.duration};
    rem_next = ge ? DUR_W'(trial - {1'b0, cfg.duration}) : trial[DUR_W-1:0];
  end

  always_comb begin
    a11 = {1'b0, alpha, 3'b000} + {3'b000, alpha, 1'b0} + {4'b0000, alpha};
    a22 = {a11, 1'b0};
    if (a11 < LIM4) begin
      m = 5'd0;  c = 6'd0;
    end else if (a11 < LIM8) begin
      m = 5'd12; c = 6'd48;
    end else if (a11 < LIM10) begin
      m = 5'd18; c = 6'd60;
    end else begin
      m = 5'd21; c = 6'd63;
    end
    s     = $signed({1'b0, a22}) - $signed({2'b00, m, {FRAC_BITS{1'b0}}});
    s_abs = s[AW+5] ? (AW+6)'(-s) : s;
  end

  always_comb begin
    fsum   = {1'b0, sq} + ((SQ_W+1)'(seg_c) << (2 * FRAC_BITS));
    f_full = fsum >> (FRAC_BITS + 6);
    f      = (f_full > (SQ_W+1)'(ONE)) ? ONE : f_full[AW-1:0];
    unique case (cfg.mode)
      MODE_IN:    w_next = {ONE - f, 1'b0};
      MODE_OUT:   w_next = {f, 1'b0};
      MODE_INOUT: w_next = first_half ? W_W'(ONE - f) : (W_W'(ONE) + W_W'(f));
      default:    w_next = '0;
    endcase
  end

  always_comb begin
    case (axis)
      2'd0:    begin st_mul = cfg.start_x; en_mul = cfg.end_x; end
      2'd1:    begin st_mul = cfg.start_y; en_mul = cfg.end_y; end
      default: begin st_mul = cfg.start_z; en_mul = cfg.end_z; end
    endcase
    delta     = $signed({en_mul[POS_W-1], en_mul}) - $signed({st_mul[POS_W-1], st_mul});
    w_s       = $signed({1'b0, w});
    axis_prev = axis - 2'd1;
    case (axis_prev)
      2'd0:    st_add = cfg.start_x;
      2'd1:    st_add = cfg.start_y;
      default: st_add = cfg.start_z;
    endcase
    // arithmetic shift is the floor toward minus infinity
    shifted = prod >>> (FRAC_BITS + 1);
    pos_sum = st_add + shifted[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            unique case (pop_cmd.kind)
              KIND_FINISH: state <= S_DONE;
              KIND_TWEEN:  state <= S_DIV;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_DIV:  if (cnt == CNT_W'(FRAC_BITS)) state <= S_SEG;
        S_SEG:  state <= S_SQ;
        S_SQ:   state <= S_WGT;
        S_WGT:  state <= S_MUL;
        S_MUL:  if (axis == 2'd3) state <= S_DONE;
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pop_valid) begin
          rem        <= pop_cmd.t;
          cnt        <= '0;
          alpha      <= '0;
          first_half <= pop_cmd.first_half;
          unique case (pop_cmd.kind)
            KIND_FINISH: begin
              pos_x    <= cfg.end_x;
              pos_y    <= cfg.end_y;
              pos_z    <= cfg.end_z;
              finished <= 1'b1;
            end
            KIND_TWEEN: finished <= 1'b0;
            default: begin
              pos_x    <= '0;
              pos_y    <= '0;
              pos_z    <= '0;
              finished <= 1'b0;
            end
          endcase
        end
      end
      S_DIV: begin
        rem   <= rem_next;
        cnt   <= cnt + 1'b1;
        alpha <= {alpha[AW-2:0], ge};
        // zero duration gives alpha 0
        if (cnt == CNT_W'(FRAC_BITS) && cfg.duration == '0) alpha <= '0;
      end
      S_SEG: begin
        mag   <= s_abs[MAG_W-1:0];
        seg_c <= c;
      end
      S_SQ: sq <= mag * mag;
      S_WGT: begin
        w    <= w_next;
        axis <= 2'd0;
      end
      S_MUL: begin
        axis <= axis + 2'd1;
        if (axis != 2'd3) prod <= delta * w_s;
        if (axis != 2'd0) begin
          case (axis_prev)
            2'd0:    pos_x <= pos_sum;
            2'd1:    pos_y <= pos_sum;
            default: pos_z <= pos_sum;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/bemt_checker.sv
module bemt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bemt_pkg::POS_W-1:0] pos_x,
  input logic signed [bemt_pkg::POS_W-1:0] pos_y,
  input logic signed [bemt_pkg::POS_W-1:0] pos_z,
  input logic                              finished,
  input logic                              wr_en,
  input logic [bemt_pkg::IDX_W-1:0]        wr_index,
  input logic [bemt_pkg::POS_W-1:0]        wr_data
);
  import bemt_pkg::*;

  // shadow of the end-position and mode registers seen on the write port
  logic [POS_W-1:0] end_x;
  logic [POS_W-1:0] end_y;
  logic [POS_W-1:0] end_z;
  logic [1:0]       mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_x <= '0;
      end_y <= '0;
      end_z <= '0;
      mode  <= MODE_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_END_X)     end_x <= wr_data;
      if (wr_index == REG_END_Y)     end_y <= wr_data;
      if (wr_index == REG_END_Z)     end_z <= wr_data;
      if (wr_index == REG_EASE_MODE) mode  <= wr_data[1:0];
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
                               && $stable(pos_z) && $stable(finished))
    else $error("stalled result changed or dropped");

  a_finish_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> pos_x == end_x && pos_y == end_y && pos_z == end_z)
    else $error("finished result is not the end position");

  a_mode_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished && mode == MODE_NONE |-> pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("mode none gave a nonzero position");

endmodule

bind bounce_easing_motion_tween bemt_checker u_bemt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pos_x     (pos_x),
  .pos_y     (pos_y),
  .pos_z     (pos_z),
  .finished  (finished),
  .wr_en     (wr_en),
  .wr_index  (wr_index),
  .wr_data   (wr_data)
);
